>>> hdl/wppj_pkg.sv
`timescale 1ns / 1ps
package wppj_pkg;

	// signed Q31.32 working format
	typedef logic signed [63:0] q32_t;

	localparam q32_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q32_t Q_MIN = 64'sh8000_0000_0000_0000;
	localparam q32_t Q_ONE = 64'sh0000_0001_0000_0000;

	// multiplier pipeline stages: partial products, sum and saturate, sign
	localparam int QMUL_LAT = 3;

	// divider: quotient bits per stage
	localparam int QUO_W      = 64;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;

	typedef enum logic [2:0] {
		REG_FOCAL_X,
		REG_FOCAL_Y,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_EDGE_WEIGHT
	} cfg_reg_t;

	localparam logic [31:0] FOCAL_X_RST     = 32'd32768000;
	localparam logic [31:0] FOCAL_Y_RST     = 32'd32768000;
	localparam logic [31:0] CENTER_X_RST    = 32'd20971520;
	localparam logic [31:0] CENTER_Y_RST    = 32'd15728640;
	localparam logic [31:0] EDGE_WEIGHT_RST = 32'd65536;

	function automatic logic [63:0] magn(input q32_t v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [31:0] magn32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic q32_t sadd(input q32_t a, input q32_t b);
		q32_t s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			return a[63] ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

	function automatic q32_t sneg(input q32_t v);
		return (v == Q_MIN) ? Q_MAX : -v;
	endfunction

	// sign and magnitude back to saturated two's complement
	function automatic q32_t mk(input logic neg, input logic [63:0] m);
		q32_t mm;
		mm = m[63] ? Q_MAX : q32_t'(m);
		return neg ? -mm : mm;
	endfunction

	// Q.32 to Q.16 toward zero, saturated to 48 bits
	function automatic logic signed [47:0] narrow48(input q32_t v);
		logic [63:0] m;
		m = magn(v) >> 16;
		if (v[63]) begin
			if (m > 64'h0000_8000_0000_0000) m = 64'h0000_8000_0000_0000;
			return 48'(-m);
		end
		if (m > 64'h0000_7FFF_FFFF_FFFF) m = 64'h0000_7FFF_FFFF_FFFF;
		return 48'(m);
	endfunction

	// Q.32 to Q.16 toward zero, saturated to 32 bits
	function automatic logic signed [31:0] narrow32(input q32_t v);
		logic [63:0] m;
		m = magn(v) >> 16;
		if (v[63]) begin
			if (m > 64'h0000_0000_8000_0000) m = 64'h0000_0000_8000_0000;
			return 32'(-m);
		end
		if (m > 64'h0000_0000_7FFF_FFFF) m = 64'h0000_0000_7FFF_FFFF;
		return 32'(m);
	endfunction

endpackage

>>> hdl/wppj_qmul.sv
`timescale 1ns / 1ps
module wppj_qmul import wppj_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q32_t a,
	input  q32_t b,
	output q32_t p
);

	logic [63:0] am, bm;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic        neg_s1, neg_s2;
	logic [33:0] t;
	logic [63:0] up;
	logic [63:0] r_s2;
	q32_t        p_s3;

	assign am = magn(a);
	assign bm = magn(b);

	// four 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= 64'(am[31:0]) * 64'(bm[31:0]);
			lh_s1  <= 64'(am[31:0]) * 64'(bm[63:32]);
			hl_s1  <= 64'(am[63:32]) * 64'(bm[31:0]);
			hh_s1  <= 64'(am[63:32]) * 64'(bm[63:32]);
			neg_s1 <= a[63] ^ b[63];
		end
	end

	always_comb begin
		t  = 34'(ll_s1[63:32]) + 34'(lh_s1[31:0]) + 34'(hl_s1[31:0]);
		up = hh_s1 + 64'(lh_s1[63:32]) + 64'(hl_s1[63:32]) + 64'(t[33:32]);
	end

	// drop 32 fraction bits, saturate the magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			r_s2   <= (up >= 64'h8000_0000) ? 64'(Q_MAX) : {up[31:0], t[31:0]};
			neg_s2 <= neg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= neg_s2 ? -q32_t'(r_s2) : q32_t'(r_s2);
		end
	end

	assign p = p_s3;

endmodule

>>> hdl/wppj_div.sv
`timescale 1ns / 1ps
module wppj_div import wppj_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic [63:0] quo
);

	// quotient of (num << 32) / den, restoring, four bits per stage
	logic [31:0]      rem_s [DIV_STAGES];
	logic [31:0]      den_s [DIV_STAGES];
	logic [QUO_W-1:0] dvd_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];

	genvar g;
	for (g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [31:0]      rem_in, den_in, rem_nx;
		logic [QUO_W-1:0] dvd_in, quo_in, dvd_nx, quo_nx;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign den_in = den;
			assign dvd_in = {num, 32'h0};
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign den_in = den_s[g-1];
			assign dvd_in = dvd_s[g-1];
			assign quo_in = quo_s[g-1];
		end

		always_comb begin
			logic [31:0] t;
			rem_nx = rem_in;
			dvd_nx = dvd_in;
			quo_nx = quo_in;
			for (int j = 0; j < DIV_STEPS; j++) begin
				t      = {rem_nx[30:0], dvd_nx[QUO_W-1]};
				dvd_nx = dvd_nx << 1;
				if (t >= den_in) begin
					rem_nx = t - den_in;
					quo_nx = {quo_nx[QUO_W-2:0], 1'b1};
				end else begin
					rem_nx = t;
					quo_nx = {quo_nx[QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				den_s[g] <= den_in;
				dvd_s[g] <= dvd_nx;
				quo_s[g] <= quo_nx;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

>>> hdl/weighted_pinhole_projection_jacobian.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | sink      | in_valid / in_stall   | pose quaternion, translation, world point
// out     | source    | out_valid / out_stall | row_index, jac_0..jac_5, pixel_coord,
//         |           |                       | depth_bad, last
// cfg     | sink      | cfg_wr_en             | cfg_index, cfg_data
//
// one item may enter every cycle while in_stall is low; each item gives two result
// transfers (u row then v row) on the single result port; the u row holds the pipeline
// the three depth dividers work on four quotient bits per stage
// reset clears the valid bits and the row select and sets the config registers to
// their reset values; no clearing pass
// a stall on the result side freezes the whole pipeline, so nothing is lost or repeated
module weighted_pinhole_projection_jacobian import wppj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  quat_w,
	input  logic signed [31:0]  quat_x,
	input  logic signed [31:0]  quat_y,
	input  logic signed [31:0]  quat_z,
	input  logic signed [31:0]  trans_x,
	input  logic signed [31:0]  trans_y,
	input  logic signed [31:0]  trans_z,
	input  logic signed [31:0]  world_x,
	input  logic signed [31:0]  world_y,
	input  logic signed [31:0]  world_z,

	output logic                out_valid,
	input  logic                out_stall,
	output logic                row_index,
	output logic signed [47:0]  jac_0,
	output logic signed [47:0]  jac_1,
	output logic signed [47:0]  jac_2,
	output logic signed [47:0]  jac_3,
	output logic signed [47:0]  jac_4,
	output logic signed [47:0]  jac_5,
	output logic signed [47:0]  pixel_coord,
	output logic                depth_bad,
	output logic                last,

	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	// stage map
	localparam int ST_QP  = QMUL_LAT;            // quaternion products
	localparam int ST_RS  = ST_QP + 3;           // rotation matrix ready
	localparam int ST_RW  = ST_RS + QMUL_LAT;    // rotated world point terms
	localparam int ST_PC  = ST_RW + 4;           // camera point in Q16.16
	localparam int ST_DI  = ST_PC + 1;           // divider operands
	localparam int ST_DQ  = ST_DI + DIV_STAGES;  // quotients
	localparam int ST_AB  = ST_DQ + 1;           // a, b, 1/z
	localparam int ST_L1  = ST_AB + QMUL_LAT;    // first product level
	localparam int ST_L1B = ST_L1 + 1;           // 1 + a*a, 1 + b*b
	localparam int ST_L2  = ST_L1B + QMUL_LAT;   // focal products
	localparam int ST_V   = ST_L2 + 1;           // unweighted entries
	localparam int ST_L3  = ST_V + QMUL_LAT;     // weighted entries
	localparam int ST_OUT = ST_L3 + 1;           // output stage

	function automatic q32_t from_q30(input logic signed [31:0] v);
		return {{30{v[31]}}, v, 2'b00};
	endfunction

	function automatic q32_t from_q16(input logic signed [31:0] v);
		return {{16{v[31]}}, v, 16'h0};
	endfunction

	// ---------------------------------------------------------------- config
	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q, edge_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q     <= FOCAL_X_RST;
			focal_y_q     <= FOCAL_Y_RST;
			center_x_q    <= CENTER_X_RST;
			center_y_q    <= CENTER_Y_RST;
			edge_weight_q <= EDGE_WEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FOCAL_X:     focal_x_q     <= cfg_data;
				REG_FOCAL_Y:     focal_y_q     <= cfg_data;
				REG_CENTER_X:    center_x_q    <= cfg_data;
				REG_CENTER_Y:    center_y_q    <= cfg_data;
				REG_EDGE_WEIGHT: edge_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// user changes registers only while idle (unchecked); they feed the datapath directly
	q32_t fx, fy, wt, cx, cy;
	assign fx = {16'h0, focal_x_q, 16'h0};
	assign fy = {16'h0, focal_y_q, 16'h0};
	assign wt = {16'h0, edge_weight_q, 16'h0};
	assign cx = from_q16(center_x_q);
	assign cy = from_q16(center_y_q);

	// ---------------------------------------------------------------- flow control
	logic valid_s [0:ST_OUT];
	logic row_q;
	logic en;

	// the pipeline moves unless the output stage still owes a row
	assign en       = !valid_s[ST_OUT] || (!out_stall && row_q);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ST_OUT; k++) valid_s[k] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int k = 1; k <= ST_OUT; k++) valid_s[k] <= valid_s[k-1];
		end
	end

	// u row first, then v row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
		end else if (valid_s[ST_OUT] && !out_stall) begin
			row_q <= !row_q;
		end
	end

	// ---------------------------------------------------------------- input stage
	q32_t qw_s0, qx_s0, qy_s0, qz_s0;
	q32_t tv_s [0:ST_RW][3];
	q32_t wv_s [0:ST_RS][3];

	always_ff @(posedge clk) begin
		if (en) begin
			qw_s0      <= from_q30(quat_w);
			qx_s0      <= from_q30(quat_x);
			qy_s0      <= from_q30(quat_y);
			qz_s0      <= from_q30(quat_z);
			tv_s[0][0] <= from_q16(trans_x);
			tv_s[0][1] <= from_q16(trans_y);
			tv_s[0][2] <= from_q16(trans_z);
			wv_s[0][0] <= from_q16(world_x);
			wv_s[0][1] <= from_q16(world_y);
			wv_s[0][2] <= from_q16(world_z);
			for (int k = 1; k <= ST_RW; k++) tv_s[k] <= tv_s[k-1];
			for (int k = 1; k <= ST_RS; k++) wv_s[k] <= wv_s[k-1];
		end
	end

	// ---------------------------------------------------------------- rotation matrix
	q32_t xx_s3, yy_s3, zz_s3, xy_s3, xz_s3, yz_s3, wx_s3, wy_s3, wz_s3;

	wppj_qmul u_xx (.clk, .en, .a(qx_s0), .b(qx_s0), .p(xx_s3));
	wppj_qmul u_yy (.clk, .en, .a(qy_s0), .b(qy_s0), .p(yy_s3));
	wppj_qmul u_zz (.clk, .en, .a(qz_s0), .b(qz_s0), .p(zz_s3));
	wppj_qmul u_xy (.clk, .en, .a(qx_s0), .b(qy_s0), .p(xy_s3));
	wppj_qmul u_xz (.clk, .en, .a(qx_s0), .b(qz_s0), .p(xz_s3));
	wppj_qmul u_yz (.clk, .en, .a(qy_s0), .b(qz_s0), .p(yz_s3));
	wppj_qmul u_wx (.clk, .en, .a(qw_s0), .b(qx_s0), .p(wx_s3));
	wppj_qmul u_wy (.clk, .en, .a(qw_s0), .b(qy_s0), .p(wy_s3));
	wppj_qmul u_wz (.clk, .en, .a(qw_s0), .b(qz_s0), .p(wz_s3));

	q32_t rm_s4 [3][3];
	q32_t rm_s5 [3][3];
	q32_t rm_s6 [3][3];

	// diagonal: pair sums; off diagonal: product sums and differences
	always_ff @(posedge clk) begin
		if (en) begin
			rm_s4[0][0] <= sadd(yy_s3, zz_s3);
			rm_s4[1][1] <= sadd(xx_s3, zz_s3);
			rm_s4[2][2] <= sadd(xx_s3, yy_s3);
			rm_s4[0][1] <= sadd(xy_s3, sneg(wz_s3));
			rm_s4[1][0] <= sadd(xy_s3, wz_s3);
			rm_s4[0][2] <= sadd(xz_s3, wy_s3);
			rm_s4[2][0] <= sadd(xz_s3, sneg(wy_s3));
			rm_s4[1][2] <= sadd(yz_s3, sneg(wx_s3));
			rm_s4[2][1] <= sadd(yz_s3, wx_s3);
		end
	end

	// doubling, then one minus on the diagonal
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (i == j) begin
						rm_s5[i][j] <= sneg(sadd(rm_s4[i][j], rm_s4[i][j]));
						rm_s6[i][j] <= sadd(Q_ONE, rm_s5[i][j]);
					end else begin
						rm_s5[i][j] <= sadd(rm_s4[i][j], rm_s4[i][j]);
						rm_s6[i][j] <= rm_s5[i][j];
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- camera point
	q32_t mw_s9 [3][3];

	genvar gi, gj;
	for (gi = 0; gi < 3; gi++) begin : g_rw_row
		for (gj = 0; gj < 3; gj++) begin : g_rw_col
			wppj_qmul u_rw (
				.clk,
				.en,
				.a(rm_s6[gi][gj]),
				.b(wv_s[ST_RS][gj]),
				.p(mw_s9[gi][gj])
			);
		end
	end

	q32_t acc_s10 [3], acc_s11 [3], acc_s12 [3];
	q32_t m1_s10 [3], m2_s10 [3], m2_s11 [3];
	logic signed [31:0] pc_s13 [3];

	// translation first, then the three terms in column order
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				acc_s10[i] <= sadd(tv_s[ST_RW][i], mw_s9[i][0]);
				m1_s10[i]  <= mw_s9[i][1];
				m2_s10[i]  <= mw_s9[i][2];
				acc_s11[i] <= sadd(acc_s10[i], m1_s10[i]);
				m2_s11[i]  <= m2_s10[i];
				acc_s12[i] <= sadd(acc_s11[i], m2_s11[i]);
				pc_s13[i]  <= narrow32(acc_s12[i]);
			end
		end
	end

	// ---------------------------------------------------------------- depth division
	logic [31:0] numx_s14, numy_s14, den_s14;
	logic        negx_s [ST_DI:ST_DQ];
	logic        negy_s [ST_DI:ST_DQ];
	logic        bad_s  [ST_DI:ST_OUT];

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s14      <= magn32(pc_s13[0]);
			numy_s14      <= magn32(pc_s13[1]);
			den_s14       <= pc_s13[2];
			negx_s[ST_DI] <= pc_s13[0][31];
			negy_s[ST_DI] <= pc_s13[1][31];
			// depth zero or behind the camera
			bad_s[ST_DI]  <= pc_s13[2][31] || (pc_s13[2] == 32'sd0);
			for (int k = ST_DI + 1; k <= ST_DQ; k++) begin
				negx_s[k] <= negx_s[k-1];
				negy_s[k] <= negy_s[k-1];
			end
			for (int k = ST_DI + 1; k <= ST_OUT; k++) bad_s[k] <= bad_s[k-1];
		end
	end

	logic [63:0] qa_s30, qb_s30, qi_s30;

	wppj_div u_div_a (.clk, .en, .num(numx_s14), .den(den_s14), .quo(qa_s30));
	wppj_div u_div_b (.clk, .en, .num(numy_s14), .den(den_s14), .quo(qb_s30));
	// 1/z: one in Q16.16 over z
	wppj_div u_div_i (.clk, .en, .num(32'h0001_0000), .den(den_s14), .quo(qi_s30));

	q32_t a_s31, b_s31, iz_s31;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s31  <= mk(negx_s[ST_DQ], qa_s30);
			b_s31  <= mk(negy_s[ST_DQ], qb_s30);
			iz_s31 <= q32_t'(qi_s30);
		end
	end

	// ---------------------------------------------------------------- first products
	q32_t ab_s34, aa_s34, bb_s34, aiz_s34, biz_s34;
	q32_t fxa_s34, fxb_s34, fxiz_s34, fya_s34, fyb_s34, fyiz_s34;

	wppj_qmul u_ab   (.clk, .en, .a(a_s31), .b(b_s31),  .p(ab_s34));
	wppj_qmul u_aa   (.clk, .en, .a(a_s31), .b(a_s31),  .p(aa_s34));
	wppj_qmul u_bb   (.clk, .en, .a(b_s31), .b(b_s31),  .p(bb_s34));
	wppj_qmul u_aiz  (.clk, .en, .a(a_s31), .b(iz_s31), .p(aiz_s34));
	wppj_qmul u_biz  (.clk, .en, .a(b_s31), .b(iz_s31), .p(biz_s34));
	wppj_qmul u_fxa  (.clk, .en, .a(fx),    .b(a_s31),  .p(fxa_s34));
	wppj_qmul u_fxb  (.clk, .en, .a(fx),    .b(b_s31),  .p(fxb_s34));
	wppj_qmul u_fxiz (.clk, .en, .a(fx),    .b(iz_s31), .p(fxiz_s34));
	wppj_qmul u_fya  (.clk, .en, .a(fy),    .b(a_s31),  .p(fya_s34));
	wppj_qmul u_fyb  (.clk, .en, .a(fy),    .b(b_s31),  .p(fyb_s34));
	wppj_qmul u_fyiz (.clk, .en, .a(fy),    .b(iz_s31), .p(fyiz_s34));

	q32_t onea_s35, oneb_s35, ab_s35, aiz_s35, biz_s35;
	// linear focal terms: fx*a, fx*b, fx*iz, fy*a, fy*b, fy*iz
	q32_t lin_s [ST_L1B:ST_L2][6];

	always_ff @(posedge clk) begin
		if (en) begin
			onea_s35          <= sadd(Q_ONE, aa_s34);
			oneb_s35          <= sadd(Q_ONE, bb_s34);
			ab_s35            <= ab_s34;
			aiz_s35           <= aiz_s34;
			biz_s35           <= biz_s34;
			lin_s[ST_L1B][0]  <= fxa_s34;
			lin_s[ST_L1B][1]  <= fxb_s34;
			lin_s[ST_L1B][2]  <= fxiz_s34;
			lin_s[ST_L1B][3]  <= fya_s34;
			lin_s[ST_L1B][4]  <= fyb_s34;
			lin_s[ST_L1B][5]  <= fyiz_s34;
			for (int k = ST_L1B + 1; k <= ST_L2; k++) lin_s[k] <= lin_s[k-1];
		end
	end

	// ---------------------------------------------------------------- focal products
	q32_t fxab_s38, fxonea_s38, fxaiz_s38, fyoneb_s38, fyab_s38, fybiz_s38;

	wppj_qmul u_fxab   (.clk, .en, .a(fx), .b(ab_s35),   .p(fxab_s38));
	wppj_qmul u_fxonea (.clk, .en, .a(fx), .b(onea_s35), .p(fxonea_s38));
	wppj_qmul u_fxaiz  (.clk, .en, .a(fx), .b(aiz_s35),  .p(fxaiz_s38));
	wppj_qmul u_fyoneb (.clk, .en, .a(fy), .b(oneb_s35), .p(fyoneb_s38));
	wppj_qmul u_fyab   (.clk, .en, .a(fy), .b(ab_s35),   .p(fyab_s38));
	wppj_qmul u_fybiz  (.clk, .en, .a(fy), .b(biz_s35),  .p(fybiz_s38));

	q32_t v_s39 [2][6];
	q32_t pix_s [ST_V:ST_L3][2];

	// unweighted Jacobian rows and pixel coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			v_s39[0][0]  <= fxab_s38;
			v_s39[0][1]  <= sneg(fxonea_s38);
			v_s39[0][2]  <= lin_s[ST_L2][1];
			v_s39[0][3]  <= sneg(lin_s[ST_L2][2]);
			v_s39[0][4]  <= '0;
			v_s39[0][5]  <= fxaiz_s38;
			v_s39[1][0]  <= fyoneb_s38;
			v_s39[1][1]  <= sneg(fyab_s38);
			v_s39[1][2]  <= sneg(lin_s[ST_L2][3]);
			v_s39[1][3]  <= '0;
			v_s39[1][4]  <= sneg(lin_s[ST_L2][5]);
			v_s39[1][5]  <= fybiz_s38;
			pix_s[ST_V][0] <= sadd(lin_s[ST_L2][0], cx);
			pix_s[ST_V][1] <= sadd(lin_s[ST_L2][4], cy);
			for (int k = ST_V + 1; k <= ST_L3; k++) pix_s[k] <= pix_s[k-1];
		end
	end

	// ---------------------------------------------------------------- weighting
	q32_t jw_s42 [2][6];

	genvar gk, gc;
	for (gk = 0; gk < 2; gk++) begin : g_wt_row
		for (gc = 0; gc < 6; gc++) begin : g_wt_col
			wppj_qmul u_wt (
				.clk,
				.en,
				.a(wt),
				.b(v_s39[gk][gc]),
				.p(jw_s42[gk][gc])
			);
		end
	end

	// ---------------------------------------------------------------- output stage
	logic signed [47:0] jac_s43 [2][6];
	logic signed [47:0] pix_s43 [2];

	// holds both rows of one item; the row select walks through them
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				for (int j = 0; j < 6; j++) begin
					jac_s43[k][j] <= bad_s[ST_L3] ? '0 : narrow48(jw_s42[k][j]);
				end
				pix_s43[k] <= bad_s[ST_L3] ? '0 : narrow48(pix_s[ST_L3][k]);
			end
		end
	end

	assign out_valid   = valid_s[ST_OUT];
	assign row_index   = row_q;
	assign last        = row_q;
	assign depth_bad   = bad_s[ST_OUT];
	assign jac_0       = jac_s43[row_q][0];
	assign jac_1       = jac_s43[row_q][1];
	assign jac_2       = jac_s43[row_q][2];
	assign jac_3       = jac_s43[row_q][3];
	assign jac_4       = jac_s43[row_q][4];
	assign jac_5       = jac_s43[row_q][5];
	assign pixel_coord = pix_s43[row_q];

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import wppj_pkg::*;

	// one result row as seen on the output port
	typedef struct packed {
		logic               row;
		logic signed [47:0] j0, j1, j2, j3, j4, j5;
		logic signed [47:0] pix;
		logic               bad;
		logic               lst;
	} row_res_t;

	// one pose/point item
	typedef struct packed {
		logic signed [31:0] qw, qx, qy, qz;
		logic signed [31:0] tx, ty, tz;
		logic signed [31:0] wx, wy, wz;
	} pose_pt_t;

	localparam int N_RANDOM = 530;
	localparam int WD_LIMIT = 20000;
	localparam int TAIL     = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [31:0] trans_x = '0, trans_y = '0, trans_z = '0;
	logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic row_index, depth_bad, last;
	logic signed [47:0] jac_0, jac_1, jac_2, jac_3, jac_4, jac_5, pixel_coord;
	logic cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	always #4 clk = ~clk;

	weighted_pinhole_projection_jacobian uut (.*);

	// model copy of the camera registers
	logic [31:0] m_fx, m_fy, m_cx, m_cy, m_wt;

	row_res_t rows_due[$];
	int  errors = 0;
	int  idle_cycles = 0;
	int  rx_cyc = 0;
	bit  hold_off = 0;   // receiver long hold-off request
	int  hold_len = 0;

	task automatic report(input string what, input logic signed [63:0] got,
		input logic signed [63:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// truncating Q.32 product with saturation, written over 128 bits
	function automatic q32_t fx_mul(input q32_t p, input q32_t q);
		logic [127:0] pr;
		logic [63:0] m;
		pr = 128'(magn(p)) * 128'(magn(q));
		pr = pr >> 32;
		m = (pr[127:63] != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : pr[63:0];
		return mk(p[63] ^ q[63], m);
	endfunction

	function automatic q32_t q16_to_q32(input logic signed [31:0] v);
		return q32_t'(v) <<< 16;
	endfunction

	function automatic q32_t quotient_q32(input logic signed [31:0] num,
		input logic signed [31:0] den);
		logic [95:0] n;
		logic [95:0] qq;
		n = 96'(magn32(num)) << 32;
		qq = n / 96'(den);
		return mk(num[31], (qq[95:63] != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : qq[63:0]);
	endfunction

	// two result rows for one pose/point item
	task automatic project_rows(input pose_pt_t it);
		q32_t qw, qx, qy, qz, xx, yy, zz, xy, xz, yz, wx, wy, wz, s;
		q32_t rm[3][3];
		q32_t tv[3], wv[3];
		logic signed [31:0] pc[3];
		q32_t v[2][7];
		q32_t fx, fy, wt, a, b, iz, ab;
		logic bad;
		row_res_t r;
		qw = q32_t'(it.qw) <<< 2; qx = q32_t'(it.qx) <<< 2;
		qy = q32_t'(it.qy) <<< 2; qz = q32_t'(it.qz) <<< 2;
		tv[0] = q16_to_q32(it.tx); tv[1] = q16_to_q32(it.ty); tv[2] = q16_to_q32(it.tz);
		wv[0] = q16_to_q32(it.wx); wv[1] = q16_to_q32(it.wy); wv[2] = q16_to_q32(it.wz);
		xx = fx_mul(qx, qx); yy = fx_mul(qy, qy); zz = fx_mul(qz, qz);
		xy = fx_mul(qx, qy); xz = fx_mul(qx, qz); yz = fx_mul(qy, qz);
		wx = fx_mul(qw, qx); wy = fx_mul(qw, qy); wz = fx_mul(qw, qz);
		rm[0][0] = sadd(Q_ONE, sneg(sadd(sadd(yy, zz), sadd(yy, zz))));
		rm[1][1] = sadd(Q_ONE, sneg(sadd(sadd(xx, zz), sadd(xx, zz))));
		rm[2][2] = sadd(Q_ONE, sneg(sadd(sadd(xx, yy), sadd(xx, yy))));
		s = sadd(xy, sneg(wz)); rm[0][1] = sadd(s, s);
		s = sadd(xy, wz);       rm[1][0] = sadd(s, s);
		s = sadd(xz, wy);       rm[0][2] = sadd(s, s);
		s = sadd(xz, sneg(wy)); rm[2][0] = sadd(s, s);
		s = sadd(yz, sneg(wx)); rm[1][2] = sadd(s, s);
		s = sadd(yz, wx);       rm[2][1] = sadd(s, s);
		for (int i = 0; i < 3; i++) begin
			s = tv[i];
			for (int j = 0; j < 3; j++) s = sadd(s, fx_mul(rm[i][j], wv[j]));
			pc[i] = narrow32(s);
		end
		bad = (pc[2] <= 0);
		for (int k = 0; k < 2; k++)
			for (int j = 0; j < 7; j++) v[k][j] = '0;
		if (!bad) begin
			fx = q32_t'({1'b0, m_fx}) <<< 16;
			fy = q32_t'({1'b0, m_fy}) <<< 16;
			wt = q32_t'({1'b0, m_wt}) <<< 16;
			a = quotient_q32(pc[0], pc[2]);
			b = quotient_q32(pc[1], pc[2]);
			iz = q32_t'((64'd1 << 48) / 64'(pc[2]));
			ab = fx_mul(a, b);
			v[0][0] = fx_mul(fx, ab);
			v[0][1] = sneg(fx_mul(fx, sadd(Q_ONE, fx_mul(a, a))));
			v[0][2] = fx_mul(fx, b);
			v[0][3] = sneg(fx_mul(fx, iz));
			v[0][5] = fx_mul(fx, fx_mul(a, iz));
			v[0][6] = sadd(fx_mul(fx, a), q16_to_q32(m_cx));
			v[1][0] = fx_mul(fy, sadd(Q_ONE, fx_mul(b, b)));
			v[1][1] = sneg(fx_mul(fy, ab));
			v[1][2] = sneg(fx_mul(fy, a));
			v[1][4] = sneg(fx_mul(fy, iz));
			v[1][5] = fx_mul(fy, fx_mul(b, iz));
			v[1][6] = sadd(fx_mul(fy, b), q16_to_q32(m_cy));
			for (int k = 0; k < 2; k++)
				for (int j = 0; j < 6; j++) v[k][j] = fx_mul(wt, v[k][j]);
		end
		for (int k = 0; k < 2; k++) begin
			r.row = k[0];
			r.j0 = narrow48(v[k][0]); r.j1 = narrow48(v[k][1]);
			r.j2 = narrow48(v[k][2]); r.j3 = narrow48(v[k][3]);
			r.j4 = narrow48(v[k][4]); r.j5 = narrow48(v[k][5]);
			r.pix = narrow48(v[k][6]);
			r.bad = bad;
			r.lst = k[0];
			rows_due.push_back(r);
		end
	endtask

	// register write, only while nothing is in flight
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_FOCAL_X:     m_fx = val;
			REG_FOCAL_Y:     m_fy = val;
			REG_CENTER_X:    m_cx = val;
			REG_CENTER_Y:    m_cy = val;
			REG_EDGE_WEIGHT: m_wt = val;
			default: ;
		endcase
	endtask

	// wait for every expected row, then let the pipe drain fully
	task automatic drain;
		while (rows_due.size() != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	// offer one item, hold it until the transfer
	task automatic send_item(input pose_pt_t it);
		{quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z,
			world_x, world_y, world_z} <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		project_rows(it);
		@(negedge clk);
	endtask

	// drop valid, leaving a gap in the input
	task automatic go_idle;
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd32;
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// well-formed pose and a point in front of the camera, mostly
	function automatic pose_pt_t rnd_item;
		pose_pt_t it;
		real ang, ax, ay, az, nrm;
		if ($urandom_range(0, 9) == 0) begin
			it = {rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
				rnd32(), rnd32(), rnd32()};
			return it;
		end
		ang = ($urandom_range(0, 2000) - 1000) / 3000.0;
		ax = $urandom_range(1, 100); ay = $urandom_range(0, 100);
		az = $urandom_range(0, 100);
		nrm = $sqrt(ax * ax + ay * ay + az * az);
		it.qw = $rtoi($cos(ang) * 1073741824.0);
		it.qx = $rtoi($sin(ang) * ax / nrm * 1073741824.0);
		it.qy = $rtoi($sin(ang) * ay / nrm * 1073741824.0);
		it.qz = $rtoi($sin(ang) * az / nrm * 1073741824.0);
		it.tx = $signed($urandom_range(0, 262144)) - 131072;
		it.ty = $signed($urandom_range(0, 262144)) - 131072;
		it.tz = $signed($urandom_range(0, 131072)) - 65536;
		it.wx = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		it.wy = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		// occasional tiny or behind-camera depth
		case ($urandom_range(0, 7))
			0: it.wz = $signed($urandom_range(0, 4)) - 2 - it.tz;
			1: it.wz = -$signed($urandom_range(1, 1 << 20));
			default: it.wz = $urandom_range(1 << 16, 1 << 22);
		endcase
		return it;
	endfunction

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [31:0] ONE16   = 32'h0001_0000;

	// directed rows: pose, point, and optionally typed expectation of the u row
	typedef struct {
		pose_pt_t it;
		bit       typed;
		row_res_t u_want;
	} dir_row_t;

	dir_row_t dir_tab[$];

	function automatic row_res_t zero_row(input logic bad);
		row_res_t r;
		r = '0;
		r.bad = bad;
		return r;
	endfunction

	task automatic build_table;
		dir_row_t d;
		row_res_t u;
		// identity pose, point on axis at depth 1: u = cx, depth fine
		u = zero_row(1'b0);
		u.j1 = -48'sd500 <<< 16; u.j3 = -48'sd500 <<< 16; u.pix = 48'sd320 <<< 16;
		d.it = {Q30_ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE16};
		d.typed = 1; d.u_want = u; dir_tab.push_back(d);
		// zero depth
		d.it = {Q30_ONE, 96'd0, 96'd0, 96'd0};
		d.typed = 1; d.u_want = zero_row(1'b1); dir_tab.push_back(d);
		// negative depth, behind camera
		d.it = {Q30_ONE, 96'd0, 96'd0, 64'd0, 32'hFFFF_0000};
		d.typed = 1; d.u_want = zero_row(1'b1); dir_tab.push_back(d);
		// tiny positive depth that truncates to zero: z row scaled by one half,
		// point at one lsb of depth
		d.it = {32'd0, 32'h2000_0000, 32'd0, 32'd0, 96'd0, 64'd0, 32'd1};
		d.typed = 1; d.u_want = zero_row(1'b1); dir_tab.push_back(d);
		d.typed = 0;
		// field extremes everywhere
		d.it = {10{32'h7FFF_FFFF}}; dir_tab.push_back(d);
		d.it = {10{32'h8000_0000}}; dir_tab.push_back(d);
		d.it = {10{32'hFFFF_FFFF}}; dir_tab.push_back(d);
		d.it = {10{32'h5555_5555}}; dir_tab.push_back(d);
		d.it = {10{32'hAAAA_AAAA}}; dir_tab.push_back(d);
		// non-unit quaternion
		d.it = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 96'd0, ONE16, ONE16, ONE16};
		dir_tab.push_back(d);
		// depth of one lsb, huge reciprocal and ratios
		d.it = {Q30_ONE, 96'd0, 32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
		dir_tab.push_back(d);
		d.it = {Q30_ONE, 96'd0, 64'd0, 32'h7FFF_FFFF, 32'h0010_0000, 32'hFFF0_0000, 32'd0};
		dir_tab.push_back(d);
		// quarter turns about each axis
		d.it = {32'h2D41_3CCD, 32'h2D41_3CCD, 64'd0, 96'd0, ONE16, ONE16, ONE16};
		dir_tab.push_back(d);
		d.it = {32'h2D41_3CCD, 32'd0, 32'h2D41_3CCD, 32'd0, 96'd0, ONE16, 32'd0, ONE16};
		dir_tab.push_back(d);
		d.it = {32'h2D41_3CCD, 64'd0, 32'h2D41_3CCD, 64'd0, 32'h0005_0000, ONE16,
			ONE16, 32'd0};
		dir_tab.push_back(d);
	endtask

	// receiver: stall pattern of its own, plus one long hold-off on request
	always @(negedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else if (hold_off) begin
			hold_off <= 1'b0;
			hold_len <= 300;
			out_stall <= 1'b1;
		end else if (rx_cyc % 400 < 150) begin
			out_stall <= 1'b0;   // stretch with no stalls
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// result checking against the oldest expected row
	always @(posedge clk) begin
		row_res_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (rows_due.size() == 0) begin
				report("unexpected row", row_index, 0);
			end else begin
				w = rows_due.pop_front();
				if (row_index !== w.row) report("row_index", row_index, w.row);
				if (jac_0 !== w.j0) report("jac_0", jac_0, w.j0);
				if (jac_1 !== w.j1) report("jac_1", jac_1, w.j1);
				if (jac_2 !== w.j2) report("jac_2", jac_2, w.j2);
				if (jac_3 !== w.j3) report("jac_3", jac_3, w.j3);
				if (jac_4 !== w.j4) report("jac_4", jac_4, w.j4);
				if (jac_5 !== w.j5) report("jac_5", jac_5, w.j5);
				if (pixel_coord !== w.pix) report("pixel_coord", pixel_coord, w.pix);
				if (depth_bad !== w.bad) report("depth_bad", depth_bad, w.bad);
				if (last !== w.lst) report("last", last, w.lst);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WD_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] fx_set[4], wt_set[4];
		row_res_t typed_u;
		int burst;
		m_fx = FOCAL_X_RST; m_fy = FOCAL_Y_RST;
		m_cx = CENTER_X_RST; m_cy = CENTER_Y_RST; m_wt = EDGE_WEIGHT_RST;
		build_table();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table under reset register values
		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].it);
			if (dir_tab[i].typed) begin
				// the u row of this item was just queued at the back, second last
				typed_u = rows_due[rows_due.size() - 2];
				if (typed_u !== dir_tab[i].u_want)
					report("directed table row", i, 0);
			end
			if (i % 3 == 2) go_idle();
		end
		go_idle();
		drain();

		// register settings, extremes among them
		fx_set = '{32'd0, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_8000};
		wt_set = '{32'hFFFF_FFFF, 32'd0, 32'h0002_0000, 32'h0000_4000};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				write_reg(REG_FOCAL_X, fx_set[ph - 1]);
				write_reg(REG_FOCAL_Y, fx_set[(ph + 1) % 4]);
				write_reg(REG_CENTER_X, (ph == 1) ? 32'h8000_0000 :
					(ph == 2) ? 32'h7FFF_FFFF : $urandom);
				write_reg(REG_CENTER_Y, (ph == 1) ? 32'h7FFF_FFFF :
					(ph == 2) ? 32'h8000_0000 : $urandom);
				write_reg(REG_EDGE_WEIGHT, wt_set[ph - 1]);
			end
			for (int n = 0; n < N_RANDOM / 5; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++) begin
					if (ph == 2 && n == 20) hold_off <= 1'b1;
					send_item(rnd_item());
				end
				go_idle();
				if (ph == 3 && n > 40 && n < 55) begin
					// sender waits for every expected row
					while (rows_due.size() != 0) @(negedge clk);
				end else begin
					repeat ($urandom_range(0, 6)) @(negedge clk);
				end
			end
			go_idle();
			drain();
		end

		if (errors == 0 && rows_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/wppj_pkg.sv
hdl/wppj_qmul.sv
hdl/wppj_div.sv
hdl/weighted_pinhole_projection_jacobian.sv
verif/tb.sv
